@@ src/tkst_pkg.sv @@
package tkst_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = 5;
  localparam int POS_W = 5;
  localparam int ID_W = 16;
  localparam int SCORE_W = 32;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = CNT_W'(10);
  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_INSERT
  } seq_state_t;

  typedef struct packed {
    logic remove;
    logic insert;
  } seq_ctl_t;

  typedef struct packed {
    logic remove;
    logic insert;
    logic occupied;
    logic in_limit;
  } cell_ctl_t;

endpackage

@@ src/tkst_cell.sv @@
module tkst_cell
  import tkst_pkg::*;
(
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [ID_W-1:0] key_id,
  input  entry_t          ins_entry,
  input  entry_t          left,
  input  entry_t          right,
  input  logic            found_in,
  output logic            found_out,
  output logic            first,
  output entry_t          entry
);

  logic hit;

  always_comb begin
    hit = 1'b0;
    if (ctl.remove) begin
      hit = ctl.occupied && (entry.id == key_id);
    end else if (ctl.insert) begin
      hit = ctl.in_limit &&
            (!ctl.occupied || ($signed(ins_entry.score) > $signed(entry.score)));
    end
  end

  assign found_out = found_in | hit;
  assign first     = hit & ~found_in;

  always_ff @(posedge clk) begin
    if (ctl.remove) begin
      // close the gap: everything at or after the match moves up one rank
      if (found_in || hit) begin
        entry <= right;
      end
    end else if (ctl.insert) begin
      if (found_in) begin
        entry <= left;
      end else if (hit) begin
        entry <= ins_entry;
      end
    end
  end

endmodule

@@ src/tkst_seq.sv @@
module tkst_seq
  import tkst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output seq_ctl_t ctl
);

  seq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (start) begin
          state_next = SEQ_INSERT;
        end
      end
      SEQ_INSERT: state_next = SEQ_IDLE;
      default:    state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    ctl.remove = 1'b0;
    ctl.insert = 1'b0;
    unique case (state)
      SEQ_IDLE: begin
        ctl.remove = start;
      end
      SEQ_INSERT: begin
        busy       = 1'b1;
        ctl.insert = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ src/top_k_score_table_update.sv @@
// Channel  | Signals                                   | Handshake
// ---------+-------------------------------------------+----------------------------
// item in  | start, busy, player_id, score             | taken when start && !busy
// result   | done, in_table, new_position, old_position | done high one cycle, no stall
// config   | cfg_valid, cfg_ready, max_entries         | written when valid && ready
//
// Each item is handled in a remove step, in the cycle that takes it, that shifts the
// old entry out of the cell row, then an insert step (SEQ_INSERT) that shifts the
// new entry in; done is registered from it. busy is high in the insert step, so no
// new item is taken then. rst resets the fill count, done, sequencer and limit.
// The result side cannot stall, so nothing is held back on that side.
module top_k_score_table_update
  import tkst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ID_W-1:0]           player_id,
  input  logic signed [SCORE_W-1:0] score,
  output logic                      done,
  output logic                      in_table,
  output logic [POS_W-1:0]          new_position,
  output logic [POS_W-1:0]          old_position,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CNT_W-1:0]          max_entries
);

  seq_ctl_t            ctl;
  logic [CNT_W-1:0]    limit_reg;
  logic [CNT_W-1:0]    limit;
  logic [CNT_W-1:0]    count;
  logic [CNT_W:0]      count_inc;
  logic [CNT_W:0]      count_next;
  entry_t              item;
  entry_t              cells   [CAPACITY];
  logic [CAPACITY:0]   found;
  logic [CAPACITY-1:0] first;
  logic [POS_W-1:0]    hit_pos;
  logic [POS_W-1:0]    old_pos;

  tkst_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= MAX_ENTRIES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_reg <= max_entries;
    end
  end

  assign limit = (limit_reg > CAP_COUNT) ? CAP_COUNT : limit_reg;

  assign found[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      cell_ctl_t cctl;
      entry_t    left_e;
      entry_t    right_e;

      assign cctl.remove   = ctl.remove;
      assign cctl.insert   = ctl.insert;
      assign cctl.occupied = (CNT_W'(g) < count);
      assign cctl.in_limit = (CNT_W'(g) < limit);

      if (g == 0) begin : g_first
        assign left_e = '0;
      end else begin : g_mid
        assign left_e = cells[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = cells[g+1];
      end

      tkst_cell u_cell (
        .clk       (clk),
        .ctl       (cctl),
        .key_id    (player_id),
        .ins_entry (item),
        .left      (left_e),
        .right     (right_e),
        .found_in  (found[g]),
        .found_out (found[g+1]),
        .first     (first[g]),
        .entry     (cells[g])
      );
    end
  endgenerate

  // one-hot first hit to a 1-based rank
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        hit_pos = hit_pos | POS_W'(i + 1);
      end
    end
  end

  assign count_inc = {1'b0, count} + (CNT_W+1)'(1);

  always_comb begin
    count_next = {1'b0, count};
    if (ctl.remove) begin
      if (found[CAPACITY]) begin
        count_next = {1'b0, count} - (CNT_W+1)'(1);
      end
    end else if (ctl.insert) begin
      if (found[CAPACITY]) begin
        count_next = (count_inc > {1'b0, CAP_COUNT}) ? {1'b0, CAP_COUNT} : count_inc;
      end
      // trim to the limit
      if (count_next > {1'b0, limit}) begin
        count_next = {1'b0, limit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next[CNT_W-1:0];
      done  <= ctl.insert;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.remove) begin
      item.id    <= player_id;
      item.score <= score;
      old_pos    <= hit_pos;
    end
    if (ctl.insert) begin
      in_table     <= found[CAPACITY];
      new_position <= hit_pos;
      old_position <= old_pos;
    end
  end

endmodule

@@ src/tkst_checker.sv @@
module tkst_checker
  import tkst_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic             in_table,
  input logic [POS_W-1:0] new_position,
  input logic [POS_W-1:0] old_position
);

  // an accepted item yields its result on done
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result did not follow accepted item");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result without a busy cycle before it");

  a_in_table_rank: assert property (@(posedge clk) disable iff (rst)
    done |-> (in_table == (new_position != '0)))
    else $error("in_table disagrees with new_position");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((new_position <= POS_W'(CAPACITY)) && (old_position <= POS_W'(CAPACITY))))
    else $error("rank beyond table capacity");

endmodule

bind top_k_score_table_update tkst_checker u_tkst_checker (.*);
